### rtl/tsm_pkg.sv
// ----------------------------------------------------------------------------
// Typed stack machine package
// Shared command, error and state codes, tagged entry and divider request.
// ----------------------------------------------------------------------------
package tsm_pkg;

  typedef enum logic [4:0] {
    CMD_NEG = 5'd0, CMD_NOT = 5'd1, CMD_ADD = 5'd2, CMD_SUB = 5'd3,
    CMD_MUL = 5'd4, CMD_DIV = 5'd5, CMD_MOD = 5'd6, CMD_EQ = 5'd7,
    CMD_NE = 5'd8, CMD_LT = 5'd9, CMD_LE = 5'd10, CMD_GT = 5'd11,
    CMD_GE = 5'd12, CMD_AND = 5'd13, CMD_OR = 5'd14, CMD_LDC = 5'd15,
    CMD_PRINT = 5'd16, CMD_HALT = 5'd17, CMD_DECL = 5'd18,
    CMD_LDV = 5'd19, CMD_STV = 5'd20
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0, ERR_UNDER = 3'd1, ERR_TYPE = 3'd2, ERR_DIV0 = 3'd3,
    ERR_MOD0 = 3'd4, ERR_BADVAR = 3'd5, ERR_OVER = 3'd6, ERR_FULL = 3'd7
  } err_t;

  typedef struct packed {
    logic        tag;
    logic [31:0] val;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

endpackage

### rtl/tsm_div.sv
// ----------------------------------------------------------------------------
// Typed stack machine divider
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsm_div (
  input  logic             clk,
  input  logic             rst_n,
  input  tsm_pkg::div_req_t req,
  output logic             done,
  output logic [31:0]      result
);
  import tsm_pkg::*;

  logic [31:0] q_r, q_nxt, rem_r, rem_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt, negq_r, negq_nxt, negr_r, negr_nxt;
  logic        mod_r, mod_nxt;
  logic [32:0] trial, shifted;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; negq_nxt = negq_r; negr_nxt = negr_r;
    mod_nxt = mod_r;
    shifted = {rem_r, q_r[31]};
    trial = shifted - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.a[31] ? (32'd0 - req.a) : req.a;
      d_nxt = req.b[31] ? (32'd0 - req.b) : req.b;
      rem_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
      negq_nxt = req.a[31] ^ req.b[31];
      negr_nxt = req.a[31];
      mod_nxt = req.is_mod;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    negq_r <= negq_nxt; negr_r <= negr_nxt; mod_r <= mod_nxt;
  end

  assign done = done_r;
  assign result = mod_r ? (negr_r ? (32'd0 - rem_r) : rem_r)
                        : (negq_r ? (32'd0 - q_r) : q_r);

  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("divider did not start");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 6'd0)) else $error("divider count ran out");
endmodule

### rtl/typed_stack_machine_alu.sv
// ----------------------------------------------------------------------------
// Typed stack machine ALU
// Each command passes through the idle, read, execute and output states;
// divide and modulus wait in a divider state, one quotient bit per cycle.
// The next input waits for the result transfer, so no new command is taken
// before the last one is through; output stalls hold it further.
// The stack memory has two read ports and the variable store one, read in the
// cycle before the update. Reset clears the stack pointer, declared count,
// written flags and halt, and returns the state to idle.
// ----------------------------------------------------------------------------
module typed_stack_machine_alu #(
  parameter int STACK_DEPTH = 64,
  parameter int VAR_SLOTS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_command,
  input  logic signed [31:0] in_const_value,
  input  logic        in_const_type,
  input  logic [5:0]  in_var_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_print_valid,
  output logic signed [31:0] out_print_value,
  output logic        out_print_type,
  output logic [2:0]  out_error_code,
  output logic        out_halted,
  output logic [6:0]  out_stack_depth
);
  import tsm_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
  localparam int DCW = $clog2(VAR_SLOTS + 1);

  entry_t stk_mem [STACK_DEPTH];
  entry_t var_mem [VAR_SLOTS];
  logic [VAR_SLOTS-1:0] wr_r, wr_nxt;

  state_t state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [DCW-1:0] dc_r, dc_nxt;
  logic halt_r, halt_nxt;
  logic [4:0]  cmd_r, cmd_nxt;
  logic [31:0] cval_r, cval_nxt;
  logic        ctype_r, ctype_nxt;
  logic [5:0]  idx_r, idx_nxt;
  entry_t top_r, sec_r, vrd_r;
  logic [SAW-1:0] ra0, ra1;
  logic [VAW-1:0] vra;
  logic [SAW-1:0] swa;
  entry_t swd;
  logic   swe;
  logic [VAW-1:0] vwa;
  logic   vwe;
  logic pv_r, pv_nxt, ptype_r, ptype_nxt;
  logic [31:0] pval_r, pval_nxt;
  logic [2:0] err_r, err_nxt;
  logic [31:0] mul_r, mul_nxt;
  div_req_t dreq;
  logic ddone;
  logic [31:0] dres;

  tsm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .result(dres));

  logic [SPW-1:0] sp_m1, sp_m2;
  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);
  assign ra0 = SAW'(sp_m1);
  assign ra1 = SAW'(sp_m2);
  assign vra = VAW'(idx_r);

  // Two read ports on the stack, one on the store; written at one address.
  always_ff @(posedge clk) begin
    top_r <= stk_mem[ra0];
    sec_r <= stk_mem[ra1];
    vrd_r <= var_mem[vra];
    if (swe) stk_mem[swa] <= swd;
    if (vwe) var_mem[vwa] <= top_r;
  end

  logic idx_ok, idx_lt_dc, slt_ab, slt_ba, eq_ab;
  assign idx_ok = 32'(idx_r) < 32'(VAR_SLOTS);
  assign idx_lt_dc = 32'(idx_r) < 32'(dc_r);
  assign eq_ab = sec_r.val == top_r.val;
  assign slt_ab = $signed(sec_r.val) < $signed(top_r.val);
  assign slt_ba = $signed(top_r.val) < $signed(sec_r.val);

  always_comb begin
    logic push;
    entry_t pe;
    state_nxt = state_r; sp_nxt = sp_r; dc_nxt = dc_r; halt_nxt = halt_r;
    wr_nxt = wr_r; cmd_nxt = cmd_r; cval_nxt = cval_r; ctype_nxt = ctype_r;
    idx_nxt = idx_r; pv_nxt = pv_r; pval_nxt = pval_r; ptype_nxt = ptype_r;
    err_nxt = err_r; mul_nxt = mul_r;
    swe = 1'b0; swa = SAW'(sp_r); swd = '0; vwe = 1'b0; vwa = vra;
    dreq = '0; in_ready = 1'b0; out_valid = 1'b0;
    push = 1'b0; pe = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_command; cval_nxt = in_const_value;
          ctype_nxt = in_const_type; idx_nxt = in_var_index;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        mul_nxt = sec_r.val * top_r.val;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        pv_nxt = 1'b0; pval_nxt = '0; ptype_nxt = 1'b0; err_nxt = ERR_OK;
        state_nxt = ST_OUT;
        if (!halt_r) begin
          priority if (cmd_r <= CMD_NOT) begin
            if (sp_r < SPW'(1)) err_nxt = ERR_UNDER;
            else begin
              sp_nxt = sp_m1;
              if (top_r.tag != (cmd_r == CMD_NOT)) err_nxt = ERR_TYPE;
              else begin
                push = 1'b1;
                pe.tag = (cmd_r == CMD_NOT);
                pe.val = (cmd_r == CMD_NOT) ? {31'd0, top_r.val == 32'd0}
                                            : 32'd0 - top_r.val;
              end
            end
          end else if (cmd_r <= CMD_OR) begin
            if (sp_r < SPW'(2)) err_nxt = ERR_UNDER;
            else begin
              sp_nxt = sp_m2;
              if (cmd_r >= CMD_AND) begin
                if (!sec_r.tag || !top_r.tag) err_nxt = ERR_TYPE;
                else begin
                  push = 1'b1; pe.tag = 1'b1;
                  pe.val = {31'd0, (cmd_r == CMD_AND)
                    ? (sec_r.val != 0 && top_r.val != 0)
                    : (sec_r.val != 0 || top_r.val != 0)};
                end
              end else if (sec_r.tag || top_r.tag) err_nxt = ERR_TYPE;
              else if (cmd_r >= CMD_EQ) begin
                push = 1'b1; pe.tag = 1'b1;
                unique case (cmd_r)
                  CMD_EQ: pe.val[0] = eq_ab;
                  CMD_NE: pe.val[0] = !eq_ab;
                  CMD_LT: pe.val[0] = slt_ab;
                  CMD_LE: pe.val[0] = !slt_ba;
                  CMD_GT: pe.val[0] = slt_ba;
                  default: pe.val[0] = !slt_ab;
                endcase
              end else if (cmd_r >= CMD_DIV) begin
                if (top_r.val == 32'd0)
                  err_nxt = (cmd_r == CMD_DIV) ? ERR_DIV0 : ERR_MOD0;
                else begin
                  dreq.start = 1'b1; dreq.is_mod = (cmd_r == CMD_MOD);
                  dreq.a = sec_r.val; dreq.b = top_r.val;
                  state_nxt = ST_DIV;
                end
              end else begin
                push = 1'b1;
                unique case (cmd_r)
                  CMD_ADD: pe.val = sec_r.val + top_r.val;
                  CMD_SUB: pe.val = sec_r.val - top_r.val;
                  default: pe.val = mul_r;
                endcase
              end
            end
          end else begin
            unique case (cmd_r)
              CMD_LDC: begin
                push = 1'b1; pe.tag = ctype_r;
                pe.val = ctype_r ? {31'd0, cval_r != 0} : cval_r;
              end
              CMD_PRINT: begin
                if (sp_r < SPW'(1)) err_nxt = ERR_UNDER;
                else begin
                  sp_nxt = sp_m1; pv_nxt = 1'b1;
                  pval_nxt = top_r.val; ptype_nxt = top_r.tag;
                end
              end
              CMD_HALT: halt_nxt = 1'b1;
              CMD_DECL: begin
                if (!idx_ok) err_nxt = ERR_FULL;
                else if (!idx_lt_dc) dc_nxt = DCW'(idx_r) + DCW'(1);
              end
              CMD_LDV: begin
                if (!idx_lt_dc || !idx_ok || !wr_r[vra]) err_nxt = ERR_BADVAR;
                else begin push = 1'b1; pe = vrd_r; end
              end
              CMD_STV: begin
                if (!idx_ok) err_nxt = ERR_FULL;
                else begin
                  if (!idx_lt_dc) dc_nxt = DCW'(idx_r) + DCW'(1);
                  if (sp_r < SPW'(1)) err_nxt = ERR_UNDER;
                  else begin
                    sp_nxt = sp_m1; vwe = 1'b1; wr_nxt[vra] = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        if (push) begin
          if (32'(sp_nxt) >= 32'(STACK_DEPTH)) err_nxt = ERR_OVER;
          else begin
            swe = 1'b1; swa = SAW'(sp_nxt); swd = pe; sp_nxt = sp_nxt + SPW'(1);
          end
        end
      end
      ST_DIV: begin
        if (ddone) begin
          swe = 1'b1; swa = SAW'(sp_r); swd.tag = 1'b0; swd.val = dres;
          sp_nxt = sp_r + SPW'(1);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; sp_r <= '0; dc_r <= '0; halt_r <= 1'b0; wr_r <= '0;
    end else begin
      state_r <= state_nxt; sp_r <= sp_nxt; dc_r <= dc_nxt;
      halt_r <= halt_nxt; wr_r <= wr_nxt;
    end
    cmd_r <= cmd_nxt; cval_r <= cval_nxt; ctype_r <= ctype_nxt; idx_r <= idx_nxt;
    pv_r <= pv_nxt; pval_r <= pval_nxt; ptype_r <= ptype_nxt; err_r <= err_nxt;
    mul_r <= mul_nxt;
  end

  assign out_print_valid = pv_r;
  assign out_print_value = pval_r;
  assign out_print_type = ptype_r;
  assign out_error_code = err_r;
  assign out_halted = halt_r;
  assign out_stack_depth = 7'(sp_r);

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= 32'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt cleared");
  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && state_r == ST_EXEC) |=> $stable(sp_r))
    else $error("stack moved after halt");
  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_print_valid) |-> (out_error_code == ERR_OK))
    else $error("print with error");
endmodule
